FILE: sv/rlpp_pkg.sv
// ----------------------------------------------------------------------------
// rlpp_pkg
// Types and codes shared by the length-prefixed record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rlpp_pkg;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_DONE
    } t_phase;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_LENGTH = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] FLD_TYPE   = 2'd0;
    localparam logic [1:0] FLD_LABEL  = 2'd1;
    localparam logic [1:0] FLD_USER   = 2'd2;
    localparam logic [1:0] FLD_SECRET = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    // output queue
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] entry_index;
        logic [1:0] field;
        logic [6:0] position;
        logic [7:0] value;
        logic [1:0] status;
        logic [5:0] entry_count;
        logic       last;
    } t_out;

endpackage

`default_nettype wire

FILE: sv/record_length_prefix_parser.sv
// ----------------------------------------------------------------------------
// record_length_prefix_parser
// Parses a count, then per record a type byte and three length-prefixed
// fields, and emits one word per type byte, field byte and field length,
// plus a final status word on the end-of-stream byte.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall / i_data, one stream byte per word.
// Output channel: o_valid / i_stall / o_data, one result per word.
// A byte is parsed in the cycle it is accepted; the parse state registers
// update at that edge and its results enter a four-word output queue, so the
// first result is shown on o_data from the queue register, after any
// words queued ahead of it. Throughput is one byte per cycle while the
// receiver takes words; the output port moves one word per cycle, so an
// end byte that also yields a field word (two results) leaves as two words.
// o_stall rises when fewer than two queue slots are free, which is set by
// the queue depth. When the receiver stalls, queued words hold and input
// stalls before the queue can overflow. Reset clears the parse state, any
// latched error and the queue; the next byte is taken as a record count.
// The end byte also returns the parse state to its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module record_length_prefix_parser #(
    parameter int MAX_RECORDS     = 32,
    parameter int LABEL_CAPACITY  = 32,
    parameter int USER_CAPACITY   = 64,
    parameter int SECRET_CAPACITY = 128
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire rlpp_pkg::t_in    i_data,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output rlpp_pkg::t_out        o_data
);

    localparam logic [7:0] MAX_REC_B  = 8'(MAX_RECORDS);
    localparam logic [8:0] LABEL_CAP  = 9'(LABEL_CAPACITY);
    localparam logic [8:0] USER_CAP   = 9'(USER_CAPACITY);
    localparam logic [8:0] SECRET_CAP = 9'(SECRET_CAPACITY);
    localparam logic [2:0] QDEPTH_C   = 3'(rlpp_pkg::QDEPTH);

    // parse state
    rlpp_pkg::t_phase r_phase, n_phase, w_phase;
    logic [7:0] r_rec_exp, n_rec_exp, w_rec_exp;
    logic [7:0] r_rec_num, n_rec_num, w_rec_num;
    logic [1:0] r_fld_num, n_fld_num, w_fld_num;
    logic [7:0] r_remain,  n_remain,  w_remain;
    logic [6:0] r_offset,  n_offset,  w_offset;
    logic [1:0] r_err,     n_err,     w_err;

    // output queue
    rlpp_pkg::t_out r_queue [rlpp_pkg::QDEPTH];
    logic [rlpp_pkg::QAW-1:0] r_head, r_tail;
    logic [2:0]               r_count, n_count;

    logic           w_in_acc, w_out_acc;
    logic [1:0]     w_nres;
    rlpp_pkg::t_out w_res0, w_res1;
    logic [8:0]     w_cap;
    logic [7:0]     w_b;
    logic [1:0]     w_fin_err;

    assign w_b       = i_data.data_byte;
    assign o_stall   = (r_count > (QDEPTH_C - 3'd2));
    assign w_in_acc  = i_valid && !o_stall;
    assign o_valid   = (r_count != 3'd0);
    assign w_out_acc = o_valid && !i_stall;
    assign o_data    = r_queue[r_head];

    always_comb begin
        case (r_fld_num)
            rlpp_pkg::FLD_LABEL: w_cap = LABEL_CAP;
            rlpp_pkg::FLD_USER:  w_cap = USER_CAP;
            default:             w_cap = SECRET_CAP;
        endcase
    end

    // next state: first the byte's step, then the end-of-stream return to reset
    always_comb begin
        w_phase   = r_phase;
        w_rec_exp = r_rec_exp;
        w_rec_num = r_rec_num;
        w_fld_num = r_fld_num;
        w_remain  = r_remain;
        w_offset  = r_offset;
        w_err     = r_err;
        if (r_err == rlpp_pkg::ST_OK) begin
            unique case (r_phase)
                rlpp_pkg::PH_COUNT: begin
                    if (w_b > MAX_REC_B) begin
                        w_err = rlpp_pkg::ST_COUNT;
                    end else begin
                        w_rec_exp = w_b;
                        w_rec_num = 8'd0;
                        w_fld_num = rlpp_pkg::FLD_TYPE;
                        w_phase   = (w_b == 8'd0) ? rlpp_pkg::PH_DONE : rlpp_pkg::PH_TYPE;
                    end
                end
                rlpp_pkg::PH_TYPE: begin
                    w_fld_num = rlpp_pkg::FLD_LABEL;
                    w_phase   = rlpp_pkg::PH_LEN;
                end
                rlpp_pkg::PH_LEN, rlpp_pkg::PH_DATA: begin
                    if (r_phase == rlpp_pkg::PH_LEN && {1'b0, w_b} >= w_cap) begin
                        w_err = rlpp_pkg::ST_LONG;
                    end else if ((r_phase == rlpp_pkg::PH_LEN && w_b == 8'd0) ||
                                 (r_phase == rlpp_pkg::PH_DATA && r_remain == 8'd1)) begin
                        // field complete: move on, or close the record after the secret
                        w_remain = 8'd0;
                        w_offset = 7'd0;
                        if (r_fld_num == rlpp_pkg::FLD_SECRET) begin
                            w_fld_num = rlpp_pkg::FLD_TYPE;
                            w_rec_num = r_rec_num + 8'd1;
                            w_phase   = ((r_rec_num + 8'd1) >= r_rec_exp) ?
                                        rlpp_pkg::PH_DONE : rlpp_pkg::PH_TYPE;
                        end else begin
                            w_fld_num = r_fld_num + 2'd1;
                            w_phase   = rlpp_pkg::PH_LEN;
                        end
                    end else if (r_phase == rlpp_pkg::PH_LEN) begin
                        w_remain = w_b;
                        w_offset = 7'd0;
                        w_phase  = rlpp_pkg::PH_DATA;
                    end else begin
                        w_remain = r_remain - 8'd1;
                        w_offset = r_offset + 7'd1;
                    end
                end
                rlpp_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end

        if (w_err == rlpp_pkg::ST_OK && w_phase != rlpp_pkg::PH_DONE) begin
            w_fin_err = rlpp_pkg::ST_TRUNC;
        end else begin
            w_fin_err = w_err;
        end

        n_phase   = r_phase;
        n_rec_exp = r_rec_exp;
        n_rec_num = r_rec_num;
        n_fld_num = r_fld_num;
        n_remain  = r_remain;
        n_offset  = r_offset;
        n_err     = r_err;
        if (w_in_acc) begin
            if (i_data.end_of_stream) begin
                n_phase   = rlpp_pkg::PH_COUNT;
                n_rec_exp = 8'd0;
                n_rec_num = 8'd0;
                n_fld_num = rlpp_pkg::FLD_TYPE;
                n_remain  = 8'd0;
                n_offset  = 7'd0;
                n_err     = rlpp_pkg::ST_OK;
            end else begin
                n_phase   = w_phase;
                n_rec_exp = w_rec_exp;
                n_rec_num = w_rec_num;
                n_fld_num = w_fld_num;
                n_remain  = w_remain;
                n_offset  = w_offset;
                n_err     = w_err;
            end
        end
    end

    // result words for the byte
    always_comb begin
        logic field_out;
        field_out = 1'b0;
        w_res0 = '0;
        w_res1 = '0;
        if (r_err == rlpp_pkg::ST_OK) begin
            unique case (r_phase)
                rlpp_pkg::PH_TYPE: begin
                    field_out          = 1'b1;
                    w_res0.kind        = rlpp_pkg::KIND_BYTE;
                    w_res0.field       = rlpp_pkg::FLD_TYPE;
                end
                rlpp_pkg::PH_LEN: begin
                    field_out          = ({1'b0, w_b} < w_cap);
                    w_res0.kind        = rlpp_pkg::KIND_LENGTH;
                    w_res0.field       = r_fld_num;
                end
                rlpp_pkg::PH_DATA: begin
                    field_out          = 1'b1;
                    w_res0.kind        = rlpp_pkg::KIND_BYTE;
                    w_res0.field       = r_fld_num;
                    w_res0.position    = r_offset;
                end
                rlpp_pkg::PH_COUNT, rlpp_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
        w_res0.entry_index = r_rec_num[4:0];
        w_res0.value       = w_b;
        w_res0.last        = !i_data.end_of_stream;

        w_res1.kind        = rlpp_pkg::KIND_STATUS;
        w_res1.status      = w_fin_err;
        w_res1.entry_count = (w_fin_err == rlpp_pkg::ST_OK) ? w_rec_exp[5:0] : 6'd0;
        w_res1.last        = 1'b1;

        if (!field_out) begin
            // only the status word, if any, goes out
            w_res0 = w_res1;
            w_nres = i_data.end_of_stream ? 2'd1 : 2'd0;
        end else begin
            w_nres = i_data.end_of_stream ? 2'd2 : 2'd1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_in_acc) begin
            n_count = n_count + {1'b0, w_nres};
        end
        if (w_out_acc) begin
            n_count = n_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_nres != 2'd0) begin
            r_queue[r_tail] <= w_res0;
        end
        if (w_in_acc && w_nres == 2'd2) begin
            r_queue[r_tail + 2'd1] <= w_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rlpp_pkg::PH_COUNT;
            r_rec_exp <= 8'd0;
            r_rec_num <= 8'd0;
            r_fld_num <= rlpp_pkg::FLD_TYPE;
            r_remain  <= 8'd0;
            r_offset  <= 7'd0;
            r_err     <= rlpp_pkg::ST_OK;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= 3'd0;
        end else begin
            r_phase   <= n_phase;
            r_rec_exp <= n_rec_exp;
            r_rec_num <= n_rec_num;
            r_fld_num <= n_fld_num;
            r_remain  <= n_remain;
            r_offset  <= n_offset;
            r_err     <= n_err;
            r_count   <= n_count;
            if (w_in_acc) begin
                r_tail <= r_tail + w_nres;
            end
            if (w_out_acc) begin
                r_head <= r_head + 2'd1;
            end
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QDEPTH_C)
        else $error("output queue overflow");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_data.end_of_stream) |=>
            (r_phase == rlpp_pkg::PH_COUNT && r_err == rlpp_pkg::ST_OK))
        else $error("parse state not cleared after end byte");

    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_err != rlpp_pkg::ST_OK) |->
            (w_nres == (i_data.end_of_stream ? 2'd1 : 2'd0)))
        else $error("field word produced after error");

    a_record_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rlpp_pkg::PH_TYPE || r_phase == rlpp_pkg::PH_LEN ||
         r_phase == rlpp_pkg::PH_DATA) |-> (r_rec_num < r_rec_exp))
        else $error("record number past expected count");

endmodule

`default_nettype wire
